>>> rtl/sysex_bulk_frame_checker_unit_defines.svh
// Assertion macros used by the bulk frame checker RTL.
`ifndef SYSEX_BULK_FRAME_CHECKER_UNIT_DEFINES_SVH
`define SYSEX_BULK_FRAME_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Implication into the next cycle.
`define SBFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbfc assertion failed");

// Implication in the same cycle.
`define SBFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbfc assertion failed");

`else

`define SBFC_ASSERT_NEXT(lbl, ante, cons)
`define SBFC_ASSERT_NOW(lbl, ante, cons)

`endif

`endif

>>> rtl/sbfc_pkg.sv
// Types and constants of the bulk frame checker.
package sbfc_pkg;

  localparam int HEADER_LEN = 8;
  localparam logic [3:0] BODY_START = 4'd10;  // position where earlier byte is a body byte
  localparam logic [3:0] SHORT_POS  = 4'd12;  // final byte below this: under 13 bytes
  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [7:0] END_BYTE   = 8'hF7;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_END    = 3'd3;
  localparam logic [2:0] ST_BAD_SUM    = 3'd4;
  localparam logic [2:0] ST_UNEXPECTED = 3'd5;

  // Config register indexes.
  localparam logic CFG_TRANSFER = 1'b0;
  localparam logic CFG_IMPORT   = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] sum;
  } result_t;

  // Fixed bulk header, position 0 through 7.
  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0: b = 8'hF0;
      3'd1: b = 8'h43;
      3'd2: b = 8'h7D;
      3'd3: b = 8'h30;
      3'd4: b = 8'h55;
      3'd5: b = 8'h42;
      3'd6: b = 8'h39;
      3'd7: b = 8'h39;
      default: b = 8'h39;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/sbfc_frame_track.sv
// Per-frame state and final status evaluation.
module sbfc_frame_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  sbfc_pkg::beat_t  beat,
  input  logic             transfer_active,
  input  logic             import_active,
  output sbfc_pkg::result_t result
);
  import sbfc_pkg::*;

  logic [3:0] pos;
  logic       hdr_ok;
  logic [7:0] body_sum;
  logic [7:0] prev_byte;
  logic [7:0] earlier_byte;

  logic       hdr_ok_next;
  logic [7:0] body_sum_next;
  logic [6:0] check;

  // Header match including this beat, and running body sum including the byte two beats back
  always_comb begin
    hdr_ok_next = hdr_ok;
    if (pos < 4'(HEADER_LEN) && beat.data != header_byte(pos[2:0])) begin
      hdr_ok_next = 1'b0;
    end
    body_sum_next = (pos >= BODY_START) ? body_sum + earlier_byte : body_sum;
    check = 7'(8'd0 - body_sum_next);
  end

  // Status, first failing test wins
  always_comb begin
    result.sum = check;
    priority if (pos < SHORT_POS) begin
      result.status = ST_SHORT;
    end else if (!hdr_ok_next) begin
      result.status = ST_BAD_HEADER;
    end else if (beat.data != END_BYTE) begin
      result.status = ST_BAD_END;
    end else if (prev_byte != {1'b0, check}) begin
      result.status = ST_BAD_SUM;
    end else if (!transfer_active && !import_active) begin
      result.status = ST_UNEXPECTED;
    end else begin
      result.status = ST_OK;
    end
  end

  // Frame state: advance on each beat, clear after the final one
  always_ff @(posedge clk) begin
    if (rst || (go && beat.last)) begin
      pos          <= '0;
      hdr_ok       <= 1'b1;
      body_sum     <= '0;
      prev_byte    <= '0;
      earlier_byte <= '0;
    end else if (go) begin
      hdr_ok       <= hdr_ok_next;
      body_sum     <= body_sum_next;
      earlier_byte <= prev_byte;
      prev_byte    <= beat.data;
      if (pos != POS_MAX) begin
        pos <= pos + 4'd1;
      end
    end
  end

endmodule

>>> rtl/sysex_bulk_frame_checker_unit.sv
// Top level of the bulk frame checker: input register, frame tracker, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_stall  | data_byte, last_byte
//  out     | out_valid / out_stall| frame_status, computed_sum
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One byte per cycle sustained while no final byte waits; a result passes from its
// final byte through the input register, then the result register, to the outputs.
// Non-final bytes never stall; a final byte waits in the input register only
// while the result register is full and stalled.
// rst is synchronous: clears frame state, config and both valid flags.
`include "sysex_bulk_frame_checker_unit_defines.svh"

module sysex_bulk_frame_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] frame_status,
  output logic [6:0] computed_sum,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);
  import sbfc_pkg::*;

  logic    a_valid;
  beat_t   a_beat;
  logic    out_free;
  logic    a_go;
  logic    transfer_active;
  logic    import_active;
  result_t track_result;
  result_t o_result;

  // Handshake between input register and result register
  assign out_free = !out_valid || !out_stall;
  assign a_go     = a_valid && (!a_beat.last || out_free);
  assign in_stall = a_valid && !a_go;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_active <= 1'b0;
      import_active   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANSFER: transfer_active <= cfg_data;
        CFG_IMPORT:   import_active   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_beat <= '{data: data_byte, last: last_byte};
    end
  end

  sbfc_frame_track u_track (
    .clk             (clk),
    .rst             (rst),
    .go              (a_go),
    .beat            (a_beat),
    .transfer_active (transfer_active),
    .import_active   (import_active),
    .result          (track_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_go && a_beat.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_beat.last) begin
      o_result <= track_result;
    end
  end

  assign frame_status = o_result.status;
  assign computed_sum = o_result.sum;

  // Checks
  `SBFC_ASSERT_NOW(a_body_no_stall, a_valid && !a_beat.last, !in_stall)
  `SBFC_ASSERT_NEXT(a_final_gives_result, a_go && a_beat.last, out_valid)
  `SBFC_ASSERT_NEXT(a_result_drains, out_valid && !out_stall && !(a_go && a_beat.last),
                    !out_valid)
  `SBFC_ASSERT_NOW(a_status_range, out_valid, frame_status <= ST_UNEXPECTED)

endmodule
